FILE: hw/rtl/tpd_pkg.sv
// Shared types and constants for the two-header length-prefixed deframer.
`timescale 1ns / 1ps

package tpd_pkg;

  localparam logic [7:0]  HDR_SHORT      = 8'hC1;
  localparam logic [7:0]  HDR_LONG       = 8'hC2;
  localparam logic [15:0] MIN_LEN_SHORT  = 16'd3;
  localparam logic [15:0] MIN_LEN_LONG   = 16'd4;
  localparam logic [15:0] CFG_MAX_RESET  = 16'd8192;

  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_HEADER = 2'd1,
    ERR_LENGTH = 2'd2
  } err_code_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] frame_byte;
    logic [7:0] frame_opcode;
    logic [15:0] byte_position;
    logic       frame_end;
    err_code_t  error_code;
    logic       run_last;
  } out_item_t;

  // One burst of results caused by a single input transfer.
  typedef struct packed {
    logic [2:0]      count;     // 0 to 4 results
    logic            kind;
    err_code_t       err;
    logic [7:0]      opcode;
    logic [15:0]     base_pos;
    logic            end_flag;  // last result of the burst closes the frame
    logic [3:0][7:0] bytes;
  } burst_t;

endpackage

FILE: hw/rtl/two_header_length_prefixed_deframer.sv
// Top level of the two-header length-prefixed deframer.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------------
//   in      | input     | in_valid/in_stall  | in_data  (mode, rx_byte)
//   out     | output    | out_valid/out_stall| out_data (one result per transfer)
//   cfg     | input     | cfg_valid/cfg_ready| cfg_data (max_frame_size)
//
// An input transfer is taken in every cycle while no burst is playing out;
// a transfer that completes a header flushes three or four results, one per
// cycle while out_stall is low, from the result register in tpd_emitter.
// The next input is taken in the same cycle as the last result of a burst.
// Reset (rst, synchronous) clears the parser and sets max_frame_size to 8192.
// out_stall holds the current result; in_stall rises while a burst is pending.
`timescale 1ns / 1ps

module two_header_length_prefixed_deframer (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  tpd_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tpd_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);
  import tpd_pkg::*;

  logic [15:0] max_frame_size;
  logic        accept;
  logic        can_load;
  burst_t      burst;

  // Configuration is always taken; the register only feeds the length check.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_size <= CFG_MAX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_frame_size <= cfg_data;
    end
  end

  // Hold the input until the result register can take the whole burst.
  assign in_stall = !can_load;
  assign accept   = in_valid && !in_stall;

  // Advance the parse state and build the burst for this transfer.
  tpd_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .in_data        (in_data),
    .max_frame_size (max_frame_size),
    .burst          (burst)
  );

  // Play the burst out one result per output transfer.
  tpd_emitter u_emitter (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .burst_in  (burst),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: hw/rtl/tpd_parser.sv
// Header parser and frame tracking state for the deframer.
`timescale 1ns / 1ps

module tpd_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  tpd_pkg::in_item_t  in_data,
  input  logic [15:0]        max_frame_size,
  output tpd_pkg::burst_t    burst
);
  import tpd_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_S_LEN   = 3'd1,
    PH_S_OP    = 3'd2,
    PH_L_LENHI = 3'd3,
    PH_L_LENLO = 3'd4,
    PH_L_OP    = 3'd5,
    PH_BODY    = 3'd6
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  hh0, hh0_next, hh1, hh1_next, hh2, hh2_next;
  logic        long_header, long_header_next;
  logic [15:0] frame_length, frame_length_next;
  logic [15:0] bytes_seen, bytes_seen_next;
  logic [7:0]  opcode_hold, opcode_hold_next;
  logic        halted, halted_next;

  logic [7:0]  b;
  logic [2:0]  hsize;
  logic [15:0] min_len;
  logic [16:0] seen_inc;
  logic        body_end;

  assign b        = in_data.rx_byte;
  assign hsize    = long_header ? 3'd4 : 3'd3;
  assign min_len  = long_header ? MIN_LEN_LONG : MIN_LEN_SHORT;
  assign seen_inc = {1'b0, bytes_seen} + 17'd1;
  assign body_end = seen_inc >= {1'b0, frame_length};

  always_comb begin
    phase_next        = phase;
    hh0_next          = hh0;
    hh1_next          = hh1;
    hh2_next          = hh2;
    long_header_next  = long_header;
    frame_length_next = frame_length;
    bytes_seen_next   = bytes_seen;
    opcode_hold_next  = opcode_hold;
    halted_next       = halted;

    burst.count    = 3'd0;
    burst.kind     = KIND_BYTE;
    burst.err      = ERR_NONE;
    burst.opcode   = 8'h00;
    burst.base_pos = 16'h0000;
    burst.end_flag = 1'b0;
    burst.bytes    = {b, b, b, b};

    if (in_data.mode) begin
      phase_next        = PH_IDLE;
      hh0_next          = 8'h00;
      hh1_next          = 8'h00;
      hh2_next          = 8'h00;
      long_header_next  = 1'b0;
      frame_length_next = 16'h0000;
      bytes_seen_next   = 16'h0000;
      opcode_hold_next  = 8'h00;
      halted_next       = 1'b0;
    end else if (!halted) begin
      case (phase)
        PH_S_LEN: begin
          hh1_next          = b;
          frame_length_next = {8'h00, b};
          phase_next        = PH_S_OP;
        end
        PH_L_LENHI: begin
          hh1_next          = b;
          frame_length_next = {b, 8'h00};
          phase_next        = PH_L_LENLO;
        end
        PH_L_LENLO: begin
          hh2_next          = b;
          frame_length_next = {frame_length[15:8], b};
          phase_next        = PH_L_OP;
        end
        PH_S_OP, PH_L_OP: begin
          if (frame_length < min_len || frame_length > max_frame_size) begin
            burst.count = 3'd1;
            burst.kind  = KIND_ERROR;
            burst.err   = ERR_LENGTH;
            halted_next = 1'b1;
            phase_next  = PH_IDLE;
          end else begin
            opcode_hold_next = b;
            burst.count      = hsize;
            burst.opcode     = b;
            burst.bytes      = {b, (long_header ? hh2 : b), hh1, hh0};
            burst.end_flag   = frame_length == {13'd0, hsize};
            if (burst.end_flag) begin
              phase_next      = PH_IDLE;
              bytes_seen_next = 16'h0000;
            end else begin
              phase_next      = PH_BODY;
              bytes_seen_next = {13'd0, hsize};
            end
          end
        end
        PH_BODY: begin
          burst.count    = 3'd1;
          burst.opcode   = opcode_hold;
          burst.base_pos = bytes_seen;
          burst.end_flag = body_end;
          if (body_end) begin
            phase_next      = PH_IDLE;
            bytes_seen_next = 16'h0000;
          end else begin
            bytes_seen_next = seen_inc[15:0];
          end
        end
        default: begin
          if (b == HDR_SHORT) begin
            hh0_next         = b;
            long_header_next = 1'b0;
            phase_next       = PH_S_LEN;
          end else if (b == HDR_LONG) begin
            hh0_next         = b;
            long_header_next = 1'b1;
            phase_next       = PH_L_LENHI;
          end else begin
            burst.count = 3'd1;
            burst.kind  = KIND_ERROR;
            burst.err   = ERR_HEADER;
            halted_next = 1'b1;
            phase_next  = PH_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      hh0          <= 8'h00;
      hh1          <= 8'h00;
      hh2          <= 8'h00;
      long_header  <= 1'b0;
      frame_length <= 16'h0000;
      bytes_seen   <= 16'h0000;
      opcode_hold  <= 8'h00;
      halted       <= 1'b0;
    end else if (accept) begin
      phase        <= phase_next;
      hh0          <= hh0_next;
      hh1          <= hh1_next;
      hh2          <= hh2_next;
      long_header  <= long_header_next;
      frame_length <= frame_length_next;
      bytes_seen   <= bytes_seen_next;
      opcode_hold  <= opcode_hold_next;
      halted       <= halted_next;
    end
  end

endmodule

FILE: hw/rtl/tpd_emitter.sv
// Result register that plays out one burst, one result per transfer.
`timescale 1ns / 1ps

module tpd_emitter (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  tpd_pkg::burst_t     burst_in,
  output logic                can_load,
  output logic                out_valid,
  input  logic                out_stall,
  output tpd_pkg::out_item_t  out_data
);
  import tpd_pkg::*;

  burst_t     held;
  logic       busy;
  logic [1:0] idx;
  logic       take;
  logic       last;

  assign last      = {1'b0, idx} == (held.count - 3'd1);
  assign out_valid = busy;
  assign take      = busy && !out_stall;
  assign can_load  = !busy || (take && last);

  assign out_data.result_kind   = held.kind;
  assign out_data.frame_byte    = held.bytes[idx];
  assign out_data.frame_opcode  = held.opcode;
  assign out_data.byte_position = held.base_pos + {14'd0, idx};
  assign out_data.frame_end     = held.end_flag && last;
  assign out_data.error_code    = held.err;
  assign out_data.run_last      = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else if (load) begin
      busy <= burst_in.count != 3'd0;
      idx  <= 2'd0;
    end else if (take) begin
      if (last) begin
        busy <= 1'b0;
      end
      idx <= idx + 2'd1;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      held <= burst_in;
    end
  end

endmodule
